// ===== rtl/jsld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsld_pkg
// Shared types, codes and helpers for the JSON string literal decoder.
// ----------------------------------------------------------------------------
package jsld_pkg;

    // Decoder modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_ESCAPE = 2'd2;
    localparam logic [1:0] MODE_HEX    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Character constants
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // UTF-8 limits and marks
    localparam logic [15:0] UTF8_ONE_MAX = 16'h007f;
    localparam logic [15:0] UTF8_TWO_MAX = 16'h07ff;
    localparam logic [7:0]  UTF8_LEAD2   = 8'hc0;
    localparam logic [7:0]  UTF8_LEAD3   = 8'he0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;

    // Result count codes (number of result transactions for one command)
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // Queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One queued command: up to three result transactions
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } cmd_t;

    // Queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/jsld_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsld_front
// Classifies each input byte, tracks decoder mode and builds commands.
// ----------------------------------------------------------------------------
module jsld_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    input  wire logic          input_end,
    output jsld_pkg::cmd_t     cmd,
    output logic               cmd_valid
);

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] code_reg, code_next;
    logic [4:0]  hex_dec;
    logic [15:0] code_shift;
    logic        err;

    assign hex_dec    = jsld_pkg::hex_decode(data_byte);
    assign code_shift = {code_reg[11:0], hex_dec[3:0]};

    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        code_next    = code_reg;
        cmd          = '0;
        cmd_valid    = 1'b0;
        err          = 1'b0;
        if (input_end) begin
            err = (mode_reg != jsld_pkg::MODE_IDLE);
        end else begin
            unique case (mode_reg)
                jsld_pkg::MODE_IDLE:
                begin
                    if (data_byte == jsld_pkg::CH_QUOTE) begin
                        mode_next = jsld_pkg::MODE_STRING;
                    end else begin
                        err = 1'b1;
                    end
                end
                jsld_pkg::MODE_STRING:
                begin
                    priority if (data_byte == jsld_pkg::CH_QUOTE) begin
                        mode_next  = jsld_pkg::MODE_IDLE;
                        cmd_valid  = 1'b1;
                        cmd.status = jsld_pkg::ST_DONE;
                        cmd.count  = jsld_pkg::CNT_ONE;
                    end else if (data_byte == jsld_pkg::CH_BACKSLASH) begin
                        mode_next = jsld_pkg::MODE_ESCAPE;
                    end else if (data_byte < jsld_pkg::CH_SPACE) begin
                        err = 1'b1;
                    end else begin
                        cmd_valid  = 1'b1;
                        cmd.status = jsld_pkg::ST_BYTE;
                        cmd.count  = jsld_pkg::CNT_ONE;
                        cmd.byte0  = data_byte;
                    end
                end
                jsld_pkg::MODE_ESCAPE:
                begin
                    cmd.status = jsld_pkg::ST_BYTE;
                    cmd.count  = jsld_pkg::CNT_ONE;
                    mode_next  = jsld_pkg::MODE_STRING;
                    cmd_valid  = 1'b1;
                    unique case (data_byte)
                        jsld_pkg::CH_QUOTE,
                        jsld_pkg::CH_BACKSLASH,
                        jsld_pkg::CH_SLASH: cmd.byte0 = data_byte;
                        jsld_pkg::CH_B:     cmd.byte0 = 8'h08;
                        jsld_pkg::CH_F:     cmd.byte0 = 8'h0c;
                        jsld_pkg::CH_N:     cmd.byte0 = 8'h0a;
                        jsld_pkg::CH_R:     cmd.byte0 = 8'h0d;
                        jsld_pkg::CH_T:     cmd.byte0 = 8'h09;
                        jsld_pkg::CH_U:
                        begin
                            cmd_valid    = 1'b0;
                            mode_next    = jsld_pkg::MODE_HEX;
                            hex_cnt_next = 2'd0;
                            code_next    = 16'd0;
                        end
                        default:
                        begin
                            cmd_valid = 1'b0;
                            err       = 1'b1;
                        end
                    endcase
                end
                jsld_pkg::MODE_HEX:
                begin
                    if (!hex_dec[4]) begin
                        err = 1'b1;
                    end else begin
                        code_next = code_shift;
                        if (hex_cnt_reg != 2'd3) begin
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end else begin
                            hex_cnt_next = 2'd0;
                            mode_next    = jsld_pkg::MODE_STRING;
                            cmd_valid    = 1'b1;
                            cmd.status   = jsld_pkg::ST_BYTE;
                            priority if (code_shift <= jsld_pkg::UTF8_ONE_MAX) begin
                                cmd.count = jsld_pkg::CNT_ONE;
                                cmd.byte0 = code_shift[7:0];
                            end else if (code_shift <= jsld_pkg::UTF8_TWO_MAX) begin
                                cmd.count = jsld_pkg::CNT_TWO;
                                cmd.byte0 = jsld_pkg::UTF8_LEAD2 | {3'd0, code_shift[10:6]};
                                cmd.byte1 = jsld_pkg::UTF8_CONT | {2'd0, code_shift[5:0]};
                            end else begin
                                cmd.count = jsld_pkg::CNT_THREE;
                                cmd.byte0 = jsld_pkg::UTF8_LEAD3 | {4'd0, code_shift[15:12]};
                                cmd.byte1 = jsld_pkg::UTF8_CONT | {2'd0, code_shift[11:6]};
                                cmd.byte2 = jsld_pkg::UTF8_CONT | {2'd0, code_shift[5:0]};
                            end
                        end
                    end
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end
        if (err) begin
            mode_next    = jsld_pkg::MODE_IDLE;
            hex_cnt_next = 2'd0;
            code_next    = 16'd0;
            cmd          = '0;
            cmd.status   = jsld_pkg::ST_ERROR;
            cmd.count    = jsld_pkg::CNT_ONE;
            cmd_valid    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= jsld_pkg::MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            code_reg    <= 16'd0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            code_reg    <= code_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/jsld_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsld_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module jsld_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire jsld_pkg::cmd_t   wr_cmd,
    input  wire logic             rd_en,
    output jsld_pkg::cmd_t        rd_cmd,
    output jsld_pkg::queue_stat_t stat
);

    localparam int AW = jsld_pkg::QUEUE_AW;

    jsld_pkg::cmd_t  slot_reg [jsld_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            do_wr;
    logic            do_rd;

    assign stat.full  = (count_reg == (AW+1)'(jsld_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_cmd     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/jsld_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsld_back
// Expands each queued command into its result transactions.
// ----------------------------------------------------------------------------
module jsld_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire jsld_pkg::cmd_t        head_cmd,
    input  wire jsld_pkg::queue_stat_t qstat,
    input  wire logic                  pop,
    output logic                       cmd_done,
    output logic                       empty,
    output logic [7:0]                 out_byte,
    output logic [1:0]                 status,
    output logic                       last
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign empty  = qstat.empty;
    assign take   = pop && !qstat.empty;
    assign status = head_cmd.status;
    assign last   = ((idx_reg + 2'd1) == head_cmd.count);

    // Drop the command once its final result transaction is taken
    assign cmd_done = take && last;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    out_byte = head_cmd.byte0;
            2'd1:    out_byte = head_cmd.byte1;
            default: out_byte = head_cmd.byte2;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take) begin
            idx_next = last ? 2'd0 : (idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/json_string_literal_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_literal_decoder
// Decodes a JSON string literal byte stream into raw bytes with UTF-8.
// ----------------------------------------------------------------------------
// Input channel: drive data_byte and input_end with push high; a transaction
// completes at a clock edge where push is high and full is low. One byte can
// be taken every cycle while the command queue has room.
// Result channel: while empty is low, out_byte, status and last show the
// oldest result; pop high at a clock edge takes it. last marks the final
// result caused by one input transaction.
// Results: a command enters the queue when its input transaction is taken;
// its results show once it is the oldest. Each input gives zero to three
// results; the back part sends one result per cycle while pop is high, so a
// \u escape of three UTF-8 bytes holds its command until all three are taken.
// The four-entry queue sets the sustained rate: one input per cycle while the
// receiver pops every cycle and bursts stay short. When it stalls, results
// hold on the ports, the queue fills and full rises until space returns.
// Reset: rst_n clears the decoder to idle (awaiting an opening quote) and
// empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module json_string_literal_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       input_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic [1:0]      status,
    output logic            last
);

    jsld_pkg::cmd_t        front_cmd;
    jsld_pkg::cmd_t        head_cmd;
    jsld_pkg::queue_stat_t qstat;
    logic                  front_valid;
    logic                  in_accept;
    logic                  cmd_done;

    // Accept an input transaction whenever the queue has a free slot
    assign full      = qstat.full;
    assign in_accept = push && !qstat.full;

    jsld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .input_end (input_end),
        .cmd       (front_cmd),
        .cmd_valid (front_valid)
    );

    // Hold commands that produce results; inputs that give none skip the queue
    jsld_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (in_accept && front_valid),
        .wr_cmd (front_cmd),
        .rd_en  (cmd_done),
        .rd_cmd (head_cmd),
        .stat   (qstat)
    );

    jsld_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .qstat    (qstat),
        .pop      (pop),
        .cmd_done (cmd_done),
        .empty    (empty),
        .out_byte (out_byte),
        .status   (status),
        .last     (last)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string literal decoder: a queued byte
// stream drives the input side, a decode predictor tracks every accepted
// transaction and a monitor checks each popped result against it.
// ----------------------------------------------------------------------------
module tb;
    import jsld_pkg::*;

    // Bytes that matter only to the bench
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0a;
    localparam logic [7:0] CTRL_FF  = 8'h0c;
    localparam logic [7:0] CTRL_CR  = 8'h0d;
    localparam logic [7:0] CTRL_MAX = 8'h1f;
    localparam logic [7:0] DIGIT_0  = 8'h30;
    localparam logic [7:0] DIGIT_9  = 8'h39;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_F  = 8'h46;
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_F  = 8'h66;
    localparam logic [7:0] LOWER_G  = 8'h67;
    localparam logic [7:0] LOWER_Q  = 8'h71;
    localparam logic [7:0] LOWER_X  = 8'h78;

    localparam int RANDOM_ITEMS = 150;
    localparam int IDLE_PCT     = 8;
    localparam int REPORT_LIMIT = 10;

    // One input transaction as it sits in the stimulus queue
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } raw_item_t;

    // One expected result transaction
    typedef struct packed {
        logic [7:0] value;
        logic [1:0] kind;
        logic       last_flag;
    } decoded_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       input_end = 1'b0;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    raw_item_t raw_stream[$];      // input transactions not yet offered
    decoded_t  decoded_queue[$];   // results predicted but not yet popped

    // Predictor state, mirrors the decoder's own registers
    logic [1:0]  dec_mode  = MODE_IDLE;
    logic [1:0]  hex_count = 2'd0;
    logic [15:0] code_unit = 16'h0000;

    int stim_count     = 0;
    int taken_count    = 0;
    int mismatch_count = 0;

    // Both sides run without idling while this is high
    logic steady;
    assign steady = (taken_count >= 80) && (taken_count < 160);

    json_string_literal_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .input_end (input_end),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

    always #5 clk = ~clk;

    // Hex digit value in either case: {valid, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= DIGIT_0 && b <= DIGIT_9)
            r = {1'b1, 4'(b - DIGIT_0)};
        else if (b >= LOWER_A && b <= LOWER_F)
            r = {1'b1, 4'(b - LOWER_A + 8'd10)};
        else if (b >= UPPER_A && b <= UPPER_F)
            r = {1'b1, 4'(b - UPPER_A + 8'd10)};
        return r;
    endfunction

    // Advance the predicted decoder by one accepted transaction and queue
    // every result it causes; the final one carries the last flag.
    task automatic predict_decode(input logic [7:0] b, input logic fin);
        logic [7:0] vals [3];
        logic [1:0] kind;
        logic [4:0] nib;
        logic       bad;
        int         n;
        decoded_t   res;
        begin
            n    = 0;
            kind = ST_BYTE;
            bad  = 1'b0;
            vals[0] = 8'h00;
            vals[1] = 8'h00;
            vals[2] = 8'h00;
            if (fin) begin
                // end of input only matters while a string is open
                bad = (dec_mode != MODE_IDLE);
            end else begin
                case (dec_mode)
                    MODE_IDLE: begin
                        if (b != CH_QUOTE)
                            bad = 1'b1;
                        else
                            dec_mode = MODE_STRING;
                    end
                    MODE_STRING: begin
                        if (b == CH_QUOTE) begin
                            dec_mode = MODE_IDLE;
                            kind     = ST_DONE;
                            n        = 1;
                        end else if (b == CH_BACKSLASH) begin
                            dec_mode = MODE_ESCAPE;
                        end else if (b < CH_SPACE) begin
                            bad = 1'b1;
                        end else begin
                            vals[0] = b;
                            n       = 1;
                        end
                    end
                    MODE_ESCAPE: begin
                        n = 1;
                        case (b)
                            CH_QUOTE, CH_BACKSLASH, CH_SLASH: vals[0] = b;
                            CH_B: vals[0] = CTRL_BS;
                            CH_F: vals[0] = CTRL_FF;
                            CH_N: vals[0] = CTRL_LF;
                            CH_R: vals[0] = CTRL_CR;
                            CH_T: vals[0] = CTRL_TAB;
                            CH_U: begin
                                n         = 0;
                                dec_mode  = MODE_HEX;
                                hex_count = 2'd0;
                                code_unit = 16'h0000;
                            end
                            default: begin
                                n   = 0;
                                bad = 1'b1;
                            end
                        endcase
                        if (n != 0)
                            dec_mode = MODE_STRING;
                    end
                    default: begin
                        nib = hex_nibble(b);
                        if (!nib[4]) begin
                            bad = 1'b1;
                        end else begin
                            code_unit = {code_unit[11:0], nib[3:0]};
                            if (hex_count != 2'd3) begin
                                hex_count = hex_count + 2'd1;
                            end else begin
                                // fourth digit: emit the code unit as UTF-8
                                hex_count = 2'd0;
                                dec_mode  = MODE_STRING;
                                if (code_unit <= UTF8_ONE_MAX) begin
                                    vals[0] = code_unit[7:0];
                                    n       = 1;
                                end else if (code_unit <= UTF8_TWO_MAX) begin
                                    vals[0] = UTF8_LEAD2 | {3'b000, code_unit[10:6]};
                                    vals[1] = UTF8_CONT | {2'b00, code_unit[5:0]};
                                    n       = 2;
                                end else begin
                                    vals[0] = UTF8_LEAD3 | {4'h0, code_unit[15:12]};
                                    vals[1] = UTF8_CONT | {2'b00, code_unit[11:6]};
                                    vals[2] = UTF8_CONT | {2'b00, code_unit[5:0]};
                                    n       = 3;
                                end
                            end
                        end
                    end
                endcase
            end
            if (bad) begin
                // any error drops the decoder back to idle
                dec_mode  = MODE_IDLE;
                hex_count = 2'd0;
                code_unit = 16'h0000;
                kind      = ST_ERROR;
                vals[0]   = 8'h00;
                n         = 1;
            end
            for (int k = 0; k < n; k++) begin
                res.value     = vals[k];
                res.kind      = kind;
                res.last_flag = (k == n - 1);
                decoded_queue = {decoded_queue, res};
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        raw_item_t it;
        begin
            it.data = b;
            it.fin  = 1'b0;
            raw_stream = {raw_stream, it};
            stim_count++;
        end
    endtask

    // End-of-input marker; the byte lane carries noise since it is ignored.
    // An end while idle is ignored by the block and is left out of the count.
    task automatic queue_end(input bit counted);
        raw_item_t it;
        begin
            it.data = 8'($urandom_range(255));
            it.fin  = 1'b1;
            raw_stream = {raw_stream, it};
            if (counted)
                stim_count++;
        end
    endtask

    task automatic queue_hex(input logic [3:0] n);
        begin
            if (n < 4'd10)
                queue_byte(DIGIT_0 + 8'(n));
            else if ($urandom_range(1))
                queue_byte(UPPER_A + 8'(n) - 8'd10);
            else
                queue_byte(LOWER_A + 8'(n) - 8'd10);
        end
    endtask

    task automatic queue_unicode(input logic [15:0] cu);
        begin
            queue_byte(CH_BACKSLASH);
            queue_byte(CH_U);
            queue_hex(cu[15:12]);
            queue_hex(cu[11:8]);
            queue_hex(cu[7:4]);
            queue_hex(cu[3:0]);
        end
    endtask

    // One well-formed string element: plain byte, short escape or \u escape
    task automatic queue_element();
        logic [7:0]  b;
        logic [15:0] cu;
        int          pick;
        begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                do b = 8'($urandom_range(8'hff, 8'h20));
                while (b == CH_QUOTE || b == CH_BACKSLASH);
                queue_byte(b);
            end else if (pick < 75) begin
                queue_byte(CH_BACKSLASH);
                case ($urandom_range(7))
                    0: queue_byte(CH_QUOTE);
                    1: queue_byte(CH_BACKSLASH);
                    2: queue_byte(CH_SLASH);
                    3: queue_byte(CH_B);
                    4: queue_byte(CH_F);
                    5: queue_byte(CH_N);
                    6: queue_byte(CH_R);
                    default: queue_byte(CH_T);
                endcase
            end else begin
                // spread code units over the one, two and three byte forms
                case ($urandom_range(5))
                    0: cu = 16'h0000;
                    1: cu = 16'($urandom_range(16'h007f, 16'h0001));
                    2: cu = 16'($urandom_range(16'h07ff, 16'h0080));
                    3: cu = 16'($urandom_range(16'hffff, 16'h0800));
                    4: cu = 16'($urandom_range(16'hdfff, 16'hd800));
                    default: begin
                        case ($urandom_range(4))
                            0: cu = 16'h007f;
                            1: cu = 16'h0080;
                            2: cu = 16'h07ff;
                            3: cu = 16'h0800;
                            default: cu = 16'hffff;
                        endcase
                    end
                endcase
                queue_unicode(cu);
            end
        end
    endtask

    // Break an open string in one of the ways the decoder must reject
    task automatic queue_fault();
        logic [7:0] b;
        logic [4:0] nib;
        int         digits;
        begin
            digits = $urandom_range(3);
            case ($urandom_range(5))
                0: queue_end(1'b1);
                1: queue_byte(8'($urandom_range(CTRL_MAX)));
                2: begin
                    b = 8'($urandom_range(255));
                    case (b)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F,
                        CH_N, CH_R, CH_T, CH_U: b = LOWER_X;
                        default: ;
                    endcase
                    queue_byte(CH_BACKSLASH);
                    queue_byte(b);
                end
                3: begin
                    queue_byte(CH_BACKSLASH);
                    queue_end(1'b1);
                end
                4: begin
                    queue_byte(CH_BACKSLASH);
                    queue_byte(CH_U);
                    for (int k = 0; k < digits; k++)
                        queue_hex(4'($urandom_range(15)));
                    b   = 8'($urandom_range(255));
                    nib = hex_nibble(b);
                    if (nib[4])
                        b = LOWER_G;
                    queue_byte(b);
                end
                default: begin
                    queue_byte(CH_BACKSLASH);
                    queue_byte(CH_U);
                    for (int k = 0; k < digits; k++)
                        queue_hex(4'($urandom_range(15)));
                    queue_end(1'b1);
                end
            endcase
        end
    endtask

    // A whole literal, optionally broken at a random element position
    task automatic queue_string(input bit broken);
        int len;
        int cut;
        begin
            len = $urandom_range(8);
            cut = broken ? int'($urandom_range(len)) : -1;
            queue_byte(CH_QUOTE);
            for (int k = 0; k < len; k++) begin
                if (k == cut) begin
                    queue_fault();
                    return;
                end
                queue_element();
            end
            if (cut == len)
                queue_fault();
            else
                queue_byte(CH_QUOTE);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next queued transaction, hold it while full is high,
    // and idle now and then unless the steady window is open. The predictor
    // runs at the edge where the transaction is taken.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : drive_proc
        raw_item_t nxt;
        logic      advance;
        if (!rst_n) begin
            push <= 1'b0;
        end else begin
            advance = !push || !full;
            if (push && !full) begin
                predict_decode(data_byte, input_end);
                taken_count <= taken_count + 1;
            end
            if (advance) begin
                if (raw_stream.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = raw_stream.pop_front();
                    push      <= 1'b1;
                    data_byte <= nxt.data;
                    input_end <= nxt.fin;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each popped result against the oldest prediction;
    // stall the result side at random outside the steady window.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_proc
        decoded_t want;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (decoded_queue.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result out_byte=%02h status=%0d last=%0b",
                                 $realtime, out_byte, status, last);
                end else begin
                    want = decoded_queue.pop_front();
                    if (out_byte !== want.value || status !== want.kind ||
                        last !== want.last_flag) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $write("%0t: expected out_byte=%02h status=%0d last=%0b, ",
                                   $realtime, want.value, want.kind, want.last_flag);
                            $display("got out_byte=%02h status=%0d last=%0b",
                                     out_byte, status, last);
                        end
                    end
                end
            end
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stream, release reset, drain, report.
    // ------------------------------------------------------------------
    initial begin : main_proc
        int directed_total;
        int pick;

        // Directed part: end while idle is ignored, a stray byte while idle
        // is an error, extreme pass-through bytes, a short escape, a three
        // byte \u escape in mixed case, a control byte, an unknown escape,
        // a bad hex digit and an end of input inside a string.
        queue_end(1'b0);
        queue_byte(8'h00);
        queue_byte(CH_QUOTE);
        queue_byte(8'hff);
        queue_byte(CH_SPACE);
        queue_byte(CH_BACKSLASH);
        queue_byte(CH_N);
        queue_byte(CH_BACKSLASH);
        queue_byte(CH_U);
        queue_byte(UPPER_F);
        queue_byte(LOWER_F);
        queue_byte(LOWER_F);
        queue_byte(UPPER_F);
        queue_byte(CH_QUOTE);
        queue_byte(CH_QUOTE);
        queue_byte(CTRL_MAX);
        queue_byte(CH_QUOTE);
        queue_byte(CH_BACKSLASH);
        queue_byte(LOWER_Q);
        queue_byte(CH_QUOTE);
        queue_byte(CH_BACKSLASH);
        queue_byte(CH_U);
        queue_byte(DIGIT_0);
        queue_byte(LOWER_G);
        queue_byte(CH_QUOTE);
        queue_end(1'b1);
        directed_total = stim_count;

        // Random part: mostly well-formed literals, some broken ones, and
        // a little noise between them.
        while (stim_count < directed_total + RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70)
                queue_string(1'b0);
            else if (pick < 88)
                queue_string(1'b1);
            else if (pick < 95)
                queue_byte(8'($urandom_range(255)));
            else
                queue_end(1'b0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every transaction taken, then every result popped
        while (raw_stream.size() != 0 || push)
            @(posedge clk);
        while (decoded_queue.size() != 0)
            @(posedge clk);
        // Give any stray result a chance to show up
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && decoded_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin : watchdog_proc
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
